@@ rtl/ufbs_pkg.sv @@
// Shared types and codes for the union-find by size block.
package ufbs_pkg;

    // Width of an element index on the request and result ports
    localparam int FIELD_W = 10;
    localparam int MODE_W  = 2;

    // Request codes
    localparam logic [MODE_W-1:0] MODE_FIND  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_JOIN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_COMP,
        S_LINK,
        S_LINK2,
        S_DONE
    } ufbs_state_t;

    // Finished result of one transaction
    typedef struct packed {
        logic [FIELD_W-1:0] root;
        logic               merged;
    } ufbs_result_t;

    // Sequencer status toward the top level
    typedef struct packed {
        logic idle;
        logic clearing;
        logic done;
    } ufbs_status_t;

endpackage

@@ rtl/ufbs_mem.sv @@
// Link table memory: one write port, one registered read port with write forwarding.
module ufbs_mem #(
    parameter int DEPTH = 1024,
    parameter int DW    = 12
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DW-1:0]            rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DW-1:0]            wr_data
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, forward a write to the same entry in the same cycle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/ufbs_ctrl.sv @@
// Sequencer: root walks, path compression, link by size and clearing sweep.
module ufbs_ctrl #(
    parameter int ELEMENTS = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic [ufbs_pkg::MODE_W-1:0]           mode,
    input  logic [ufbs_pkg::FIELD_W-1:0]          first_element,
    input  logic [ufbs_pkg::FIELD_W-1:0]          second_element,
    input  logic                                  res_take,
    output ufbs_pkg::ufbs_result_t                result,
    output ufbs_pkg::ufbs_status_t                status,
    output logic                                  rd_en,
    output logic [$clog2(ELEMENTS)-1:0]           rd_addr,
    input  logic [$clog2(ELEMENTS+1):0]           rd_data,
    output logic                                  wr_en,
    output logic [$clog2(ELEMENTS)-1:0]           wr_addr,
    output logic [$clog2(ELEMENTS+1):0]           wr_data
);
    import ufbs_pkg::*;

    localparam int AW = $clog2(ELEMENTS);
    localparam int VW = $clog2(ELEMENTS + 1);
    localparam logic [AW-1:0] LAST = AW'(ELEMENTS - 1);

    ufbs_state_t   state_reg, state_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] start_reg, start_next;
    logic [AW-1:0] root_reg, root_next;
    logic [VW-1:0] size_reg, size_next;
    logic [AW-1:0] x_reg, x_next;
    logic [VW-1:0] sx_reg, sx_next;
    logic [AW-1:0] y_reg, y_next;
    logic [VW-1:0] sy_reg, sy_next;
    logic [AW-1:0] b_reg, b_next;
    logic [AW-1:0] big_reg, big_next;
    logic [AW-1:0] small_reg, small_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          join_reg, join_next;
    logic          phase_reg, phase_next;
    logic          pend_reg, pend_next;
    ufbs_result_t  res_reg, res_next;

    logic          rd_is_root;
    logic [VW-1:0] rd_val;
    logic [AW-1:0] rd_par;
    logic          a_ok;
    logic          b_ok;
    logic          fin;
    logic [AW-1:0] fin_root;
    logic [VW-1:0] fin_size;

    assign rd_is_root = rd_data[VW];
    assign rd_val     = rd_data[VW-1:0];
    assign rd_par     = rd_data[AW-1:0];
    assign a_ok       = (32'(first_element) < 32'(ELEMENTS));
    assign b_ok       = (32'(second_element) < 32'(ELEMENTS));

    // State and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            join_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            join_reg  <= join_next;
            phase_reg <= phase_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        start_reg <= start_next;
        root_reg  <= root_next;
        size_reg  <= size_next;
        x_reg     <= x_next;
        sx_reg    <= sx_next;
        y_reg     <= y_next;
        sy_reg    <= sy_next;
        b_reg     <= b_next;
        big_reg   <= big_next;
        small_reg <= small_next;
        res_reg   <= res_next;
    end

    // Next state, memory accesses and results
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        start_next = start_reg;
        root_next  = root_reg;
        size_next  = size_reg;
        x_next     = x_reg;
        sx_next    = sx_reg;
        y_next     = y_reg;
        sy_next    = sy_reg;
        b_next     = b_reg;
        big_next   = big_reg;
        small_next = small_reg;
        cnt_next   = cnt_reg;
        join_next  = join_reg;
        phase_next = phase_reg;
        pend_next  = pend_reg;
        res_next   = res_reg;
        rd_en      = 1'b0;
        rd_addr    = cur_reg;
        wr_en      = 1'b0;
        wr_addr    = cur_reg;
        wr_data    = {1'b0, VW'(root_reg)};
        fin        = 1'b0;
        fin_root   = root_reg;
        fin_size   = size_reg;

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep every entry back to a singleton
                wr_en   = 1'b1;
                wr_addr = cnt_reg;
                wr_data = {1'b1, VW'(1)};
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    pend_next  = 1'b0;
                    state_next = pend_reg ? S_DONE : S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_next = '0;
                    case (mode)
                        MODE_FIND:
                        begin
                            if (a_ok)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(first_element);
                                cur_next   = AW'(first_element);
                                start_next = AW'(first_element);
                                join_next  = 1'b0;
                                phase_next = 1'b0;
                                state_next = S_WALK;
                            end
                            else
                            begin
                                res_next.root = first_element;
                                state_next    = S_DONE;
                            end
                        end
                        MODE_JOIN:
                        begin
                            if (a_ok && b_ok)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(first_element);
                                cur_next   = AW'(first_element);
                                start_next = AW'(first_element);
                                b_next     = AW'(second_element);
                                join_next  = 1'b1;
                                phase_next = 1'b0;
                                state_next = S_WALK;
                            end
                            else
                            begin
                                res_next.root = first_element;
                                state_next    = S_DONE;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            cnt_next   = '0;
                            pend_next  = 1'b1;
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // Follow parent links until a root shows up
                if (rd_is_root)
                begin
                    if (cur_reg == start_reg)
                    begin
                        fin      = 1'b1;
                        fin_root = cur_reg;
                        fin_size = rd_val;
                    end
                    else
                    begin
                        root_next  = cur_reg;
                        size_next  = rd_val;
                        rd_en      = 1'b1;
                        rd_addr    = start_reg;
                        cur_next   = start_reg;
                        state_next = S_COMP;
                    end
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = rd_par;
                    cur_next = rd_par;
                end
            end

            S_COMP:
            begin
                // Repoint each entry on the path straight at the root
                if (rd_is_root)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = cur_reg;
                    wr_data  = {1'b0, VW'(root_reg)};
                    rd_en    = 1'b1;
                    rd_addr  = rd_par;
                    cur_next = rd_par;
                end
            end

            S_LINK:
            begin
                // Grow the larger root, ties keep the first one
                wr_en         = 1'b1;
                wr_data       = {1'b1, VW'(sx_reg + sy_reg)};
                res_next.merged = 1'b1;
                if (sx_reg < sy_reg)
                begin
                    wr_addr       = y_reg;
                    big_next      = y_reg;
                    small_next    = x_reg;
                    res_next.root = FIELD_W'(y_reg);
                end
                else
                begin
                    wr_addr       = x_reg;
                    big_next      = x_reg;
                    small_next    = y_reg;
                    res_next.root = FIELD_W'(x_reg);
                end
                state_next = S_LINK2;
            end

            S_LINK2:
            begin
                // Hang the smaller root under the larger one
                wr_en      = 1'b1;
                wr_addr    = small_reg;
                wr_data    = {1'b0, VW'(big_reg)};
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Wrap up a finished walk
        if (fin)
        begin
            if (!join_reg)
            begin
                res_next.root   = FIELD_W'(fin_root);
                res_next.merged = 1'b0;
                state_next      = S_DONE;
            end
            else if (!phase_reg)
            begin
                x_next     = fin_root;
                sx_next    = fin_size;
                phase_next = 1'b1;
                rd_en      = 1'b1;
                rd_addr    = b_reg;
                cur_next   = b_reg;
                start_next = b_reg;
                state_next = S_WALK;
            end
            else if (fin_root == x_reg)
            begin
                res_next.root   = FIELD_W'(x_reg);
                res_next.merged = 1'b0;
                state_next      = S_DONE;
            end
            else
            begin
                y_next     = fin_root;
                sy_next    = fin_size;
                state_next = S_LINK;
            end
        end
    end

    assign result          = res_reg;
    assign status.idle     = (state_reg == S_IDLE);
    assign status.clearing = (state_reg == S_CLEAR);
    assign status.done     = (state_reg == S_DONE);

endmodule

@@ rtl/union_find_by_size_top.sv @@
// Top level of the union-find by size block: sequencer, link table and result register.
//
// Input channel (in_valid/in_ready) carries mode, first_element, second_element.
// Output channel (out_valid/out_ready) carries root and merged, one per transaction.
// A find walks the parent links to the root, one memory read per cycle, then walks
// the path again rewriting each entry to point at the root. Path depth stays at
// most log2(ELEMENTS) under union by size, and an element that is its own root
// skips the second walk.
// A join runs two such walks and, when the roots differ, writes the grown size of
// the larger root and then hangs the smaller root under it (S_LINK, S_LINK2).
// A clear rewrites the table one entry a cycle and then offers a result.
// Out-of-range requests and the unused mode go to the result without a table access.
// in_ready returns in the cycle after the result moves to the output register.
// The single read port of the link table sets the pace: one transaction at a time.
// After reset the table is swept to singletons; in_ready stays low during the
// sweep.
// A finished result waits in the output register; a new transaction is taken while
// it waits, and a second result holds in the sequencer until out_ready frees the slot.
module union_find_by_size_top #(
    parameter int ELEMENTS = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [ufbs_pkg::MODE_W-1:0]          mode,
    input  logic [ufbs_pkg::FIELD_W-1:0]         first_element,
    input  logic [ufbs_pkg::FIELD_W-1:0]         second_element,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ufbs_pkg::FIELD_W-1:0]         root,
    output logic                                 merged
);
    import ufbs_pkg::*;

    localparam int AW = $clog2(ELEMENTS);
    localparam int VW = $clog2(ELEMENTS + 1);
    localparam int EW = VW + 1;

    ufbs_result_t       result;
    ufbs_status_t       status;
    logic               res_take;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [EW-1:0]      rd_data;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [EW-1:0]      wr_data;
    logic               out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0] root_reg;
    logic               merged_reg;

    ufbs_ctrl #(
        .ELEMENTS (ELEMENTS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .mode           (mode),
        .first_element  (first_element),
        .second_element (second_element),
        .res_take       (res_take),
        .result         (result),
        .status         (status),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data)
    );

    ufbs_mem #(
        .DEPTH (ELEMENTS),
        .DW    (EW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Move a finished result into the output slot when it is free or being emptied
    assign res_take = status.done && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            root_reg   <= result.root;
            merged_reg <= result.merged;
        end
    end

    assign in_ready  = status.idle;
    assign out_valid = out_valid_reg;
    assign root      = root_reg;
    assign merged    = merged_reg;

    // A taken transaction keeps the sequencer busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted back to back");

    // No transaction is taken during the clearing sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> !in_ready)
        else $error("input ready during clearing sweep");

    // A moved result shows up on the output with its root
    assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> (out_valid && (root == $past(result.root))))
        else $error("result lost on the way to the output");

endmodule

@@ tb/union_find_by_size_top_tb.sv @@
// Self-checking testbench for the union-find by size block: directed and random find/join/clear.
`timescale 1ns / 100ps

module union_find_by_size_top_tb;
    import ufbs_pkg::*;

    localparam int          NUM_ELEM      = 1024;
    localparam int          RANDOM_ITEMS  = 1700;
    localparam int          QUIET_ITEMS   = 200;
    localparam int          EPOCH_ITEMS   = 120;
    localparam int          LONG_HOLD     = 500;
    localparam int          DRAIN_CYCLES  = 64;
    localparam int unsigned CYCLE_LIMIT   = 1000000;

    // Mode code the block leaves unused
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Shadow forest: tracks every entry and predicts one result per transaction
    class set_forest_tracker;
        bit             is_root[NUM_ELEM];
        int unsigned    link_val[NUM_ELEM];     // set size for a root, parent otherwise
        ufbs_result_t   pending_roots[$];
        int unsigned    mismatch_count;
        int unsigned    results_checked;
        int unsigned    find_count;
        int unsigned    join_count;
        int unsigned    merge_count;
        int unsigned    clear_count;
        int unsigned    unused_count;

        function new();
            make_singletons();
        endfunction

        function void make_singletons();
            for (int i = 0; i < NUM_ELEM; i++)
            begin
                is_root[i]  = 1'b1;
                link_val[i] = 1;
            end
        endfunction

        // Walk to the root, then point every entry on the path straight at it
        function int unsigned find_root(int unsigned e);
            int unsigned r;
            int unsigned cur;
            int unsigned nxt;
            int unsigned steps;
            r = e;
            steps = 0;
            while (!is_root[r] && steps < NUM_ELEM)
            begin
                r = link_val[r];
                steps++;
            end
            cur = e;
            steps = 0;
            while (cur != r && !is_root[cur] && steps < NUM_ELEM)
            begin
                nxt = link_val[cur];
                link_val[cur] = r;
                cur = nxt;
                steps++;
            end
            return r;
        endfunction

        // Apply one accepted transaction and queue its expected result.
        // Element fields are 10 bits wide, so they never exceed the table.
        function void note_request(logic [MODE_W-1:0] m, logic [FIELD_W-1:0] a,
                                   logic [FIELD_W-1:0] b);
            ufbs_result_t res;
            int unsigned  x;
            int unsigned  y;
            int unsigned  t;
            res = '0;
            case (m)
                MODE_FIND:
                begin
                    x = find_root(32'(a));
                    res.root = x[FIELD_W-1:0];
                    find_count++;
                end
                MODE_JOIN:
                begin
                    x = find_root(32'(a));
                    y = find_root(32'(b));
                    if (x != y)
                    begin
                        // smaller set goes under the larger; tie keeps the first root
                        if (link_val[x] < link_val[y])
                        begin
                            t = x;
                            x = y;
                            y = t;
                        end
                        link_val[x] += link_val[y];
                        is_root[y]  = 1'b0;
                        link_val[y] = x;
                        res.merged  = 1'b1;
                        merge_count++;
                    end
                    res.root = x[FIELD_W-1:0];
                    join_count++;
                end
                MODE_CLEAR:
                begin
                    make_singletons();
                    clear_count++;
                end
                default:
                begin
                    unused_count++;
                end
            endcase
            pending_roots = {pending_roots, res};
        endfunction

        task report_mismatch(string what, logic [31:0] want, logic [31:0] got);
            mismatch_count++;
            $display("[%0t] mismatch on %s: expected %0d, got %0d (result %0d)",
                     $time, what, want, got, results_checked);
        endtask

        // Compare one result transaction with the oldest expectation
        task check_result(logic [FIELD_W-1:0] got_root, logic got_merged);
            ufbs_result_t want;
            results_checked++;
            if (pending_roots.size() == 0)
            begin
                report_mismatch("unexpected result root", 32'd0, 32'(got_root));
                return;
            end
            want = pending_roots.pop_front();
            if (got_root !== want.root)
                report_mismatch("root", 32'(want.root), 32'(got_root));
            if (got_merged !== want.merged)
                report_mismatch("merged", 32'(want.merged), 32'(got_merged));
        endtask

        task flush_leftover();
            ufbs_result_t want;
            while (pending_roots.size() != 0)
            begin
                want = pending_roots.pop_front();
                report_mismatch("missing result root", 32'(want.root), 'x);
            end
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [MODE_W-1:0]    mode;
    logic [FIELD_W-1:0]   first_element;
    logic [FIELD_W-1:0]   second_element;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [FIELD_W-1:0]   root;
    logic                 merged;

    set_forest_tracker    forest = new();
    int unsigned          cycle_count;
    bit                   quiet;
    bit                   sender_idles;
    bit                   receiver_stalls;
    bit                   long_hold_done;
    int unsigned          pool_base;
    int unsigned          pool_span;

    union_find_by_size_top #(
        .ELEMENTS(NUM_ELEM)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .first_element  (first_element),
        .second_element (second_element),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .root           (root),
        .merged         (merged)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("union_find_by_size_top_tb: FAIL");
            $finish;
        end
    end

    // Check every result transaction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            forest.check_result(root, merged);
    end

    // Receiver: random stall bursts, one long hold-off, none in the quiet tail
    initial
    begin : receiver
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && forest.results_checked >= 300)
            begin
                out_ready <= 1'b0;
                long_hold_done = 1'b1;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (!quiet && receiver_stalls && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 12)) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Offer one request and hold it until accepted
    task automatic send_request(input logic [MODE_W-1:0] m, input logic [FIELD_W-1:0] a,
                                input logic [FIELD_W-1:0] b);
        @(negedge clk);
        in_valid       <= 1'b1;
        mode           <= m;
        first_element  <= a;
        second_element <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        forest.note_request(m, a, b);
    endtask

    // Drop valid and pause the sender
    task automatic pause_sender(input int unsigned n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Mostly elements from the current pool so sets grow and paths get deep
    function automatic logic [FIELD_W-1:0] pick_element();
        if ($urandom_range(0, 99) < 85)
            return FIELD_W'(pool_base + $urandom_range(0, pool_span - 1));
        return FIELD_W'($urandom_range(0, NUM_ELEM - 1));
    endfunction

    task automatic wait_drained();
        while (forest.pending_roots.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned        pick;
        logic [MODE_W-1:0]  m;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;

        rst_n           = 1'b0;
        in_valid        = 1'b0;
        mode            = MODE_FIND;
        first_element   = '0;
        second_element  = '0;
        quiet           = 1'b0;
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        pool_base       = 0;
        pool_span       = 32;

        // Hold reset low, then release it
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, every mode, ties, same-set joins, clear
        send_request(MODE_FIND,   10'd0,    10'd0);
        send_request(MODE_FIND,   10'd1023, 10'd1023);
        send_request(MODE_UNUSED, 10'd1023, 10'd1023);
        send_request(MODE_JOIN,   10'd0,    10'd1023);
        send_request(MODE_JOIN,   10'd1023, 10'd0);
        send_request(MODE_JOIN,   10'd5,    10'd6);
        send_request(MODE_JOIN,   10'd7,    10'd6);
        send_request(MODE_JOIN,   10'd0,    10'd5);
        send_request(MODE_FIND,   10'd1023, 10'd0);
        send_request(MODE_FIND,   10'd1023, 10'd682);
        send_request(MODE_JOIN,   10'd682,  10'd341);
        send_request(MODE_FIND,   10'd341,  10'd1023);
        send_request(MODE_JOIN,   10'd3,    10'd3);
        send_request(MODE_JOIN,   10'd341,  10'd7);
        send_request(MODE_FIND,   10'd682,  10'd0);
        send_request(MODE_CLEAR,  10'd1023, 10'd1023);
        send_request(MODE_FIND,   10'd1023, 10'd0);
        send_request(MODE_JOIN,   10'd6,    10'd5);
        send_request(MODE_FIND,   10'd5,    10'd0);
        send_request(MODE_UNUSED, 10'd0,    10'd0);
        send_request(MODE_CLEAR,  10'd0,    10'd0);
        pause_sender(1);
        wait_drained();

        // Random: epochs with their own element pool and idling behavior
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % EPOCH_ITEMS == 0)
            begin
                case ($urandom_range(0, 3))
                    0: pool_span = 8;
                    1: pool_span = 32;
                    2: pool_span = 128;
                    default: pool_span = NUM_ELEM;
                endcase
                pool_base       = $urandom_range(0, NUM_ELEM - 1);
                sender_idles    = ($urandom_range(0, 2) != 0);
                receiver_stalls = ($urandom_range(0, 2) != 0);
            end
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            if (i == 600)
            begin
                pause_sender(1);
                wait_drained();
            end
            if (!quiet && sender_idles && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 13));

            pick = $urandom_range(0, 199);
            if (pick < 2)
            begin
                m = MODE_CLEAR;
                a = FIELD_W'($urandom);
                b = FIELD_W'($urandom);
            end
            else if (pick < 6)
            begin
                m = MODE_UNUSED;
                a = FIELD_W'($urandom);
                b = FIELD_W'($urandom);
            end
            else if (pick < 110)
            begin
                m = MODE_JOIN;
                a = pick_element();
                b = pick_element();
            end
            else
            begin
                m = MODE_FIND;
                a = pick_element();
                b = FIELD_W'($urandom);
            end
            send_request(m, a, b);
        end

        // Drain and finish
        @(negedge clk);
        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        forest.flush_leftover();

        $display("Covered %0d finds, %0d joins (%0d merged), %0d clears, %0d unused-mode requests",
                 forest.find_count, forest.join_count, forest.merge_count,
                 forest.clear_count, forest.unused_count);
        $display("Checked %0d results in %0d cycles, %0d mismatches",
                 forest.results_checked, cycle_count, forest.mismatch_count);
        if (forest.mismatch_count == 0)
            $display("union_find_by_size_top_tb: PASS");
        else
            $display("union_find_by_size_top_tb: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/ufbs_pkg.sv
rtl/ufbs_mem.sv
rtl/ufbs_ctrl.sv
rtl/union_find_by_size_top.sv
tb/union_find_by_size_top_tb.sv
